[rtl/mck_pkg.sv]
// Shared types, widths and constants of the Monod cell kinetics block.
// No dependencies; the interfaces and the top level import this package.
package mck_pkg;

  localparam int FRAC_BITS_DEF = 40;  // default fraction bits of the fixed-point format
  localparam int CW     = 47;         // unsigned concentration and register width
  localparam int TW     = 48;         // signed reaction total width
  localparam int PW     = 2 * CW;     // full rate times density product
  localparam int P100W  = PW + 7;     // product scaled by the nitrate numerator
  localparam int QDW    = 50;         // uptake quotient width, cap is 2^49
  localparam int SUM_W  = QDW + 2;    // total plus or minus two capped terms
  localparam int NET_W  = CW + 2;     // rate minus maintenance minus decay
  localparam int DIVC_W = 7;          // width of the nitrate divisor
  localparam int CFG_IDX_W = 3;

  localparam logic [DIVC_W-1:0] NITRATE_DIV = 7'd114;
  localparam logic [DIVC_W-1:0] NITRATE_MUL = 7'd100;
  localparam logic [QDW-1:0]    TERM_CAP    = QDW'(1) << (QDW - 1);

  typedef logic [CW-1:0]        conc_t;
  typedef logic signed [TW-1:0] total_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_GROWTH = 3'd0,
    REG_YIELD      = 3'd1,
    REG_MAINT      = 3'd2,
    REG_DECAY      = 3'd3,
    REG_HALF_A     = 3'd4,
    REG_HALF_N     = 3'd5,
    REG_OXY_K      = 3'd6
  } cfg_reg_t;

  // Clamp a wide two's complement sum into the signed total range.
  function automatic total_t sat_total(input logic [SUM_W-1:0] v);
    logic [SUM_W-TW:0] top;
    total_t r;
    top = v[SUM_W-1:TW-1];
    if (top == '0 || top == '1) begin
      r = v[TW-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(TW-1){1'b0}}};
    end else begin
      r = {1'b0, {(TW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/mck_if.sv]
// Channel interfaces of the Monod cell kinetics block: cell input,
// result output and configuration write. Depends on mck_pkg.
interface mck_in_if import mck_pkg::*; ();
  logic   valid;
  logic   ready;
  conc_t  conc_ammonium;
  conc_t  conc_nitrite;
  conc_t  conc_oxygen;
  conc_t  biomass_density;
  logic   ghost_cell;
  total_t ammonium_total_in;
  total_t nitrite_total_in;
  total_t nitrate_total_in;
  modport source (output valid, conc_ammonium, conc_nitrite, conc_oxygen, biomass_density,
                  ghost_cell, ammonium_total_in, nitrite_total_in, nitrate_total_in,
                  input ready);
  modport sink (input valid, conc_ammonium, conc_nitrite, conc_oxygen, biomass_density,
                ghost_cell, ammonium_total_in, nitrite_total_in, nitrate_total_in,
                output ready);
endinterface

interface mck_out_if import mck_pkg::*; ();
  logic   valid;
  logic   ready;
  total_t ammonium_total_out;
  total_t nitrite_total_out;
  total_t nitrate_total_out;
  total_t net_growth_rate;
  logic   growth_valid;
  modport source (output valid, ammonium_total_out, nitrite_total_out, nitrate_total_out,
                  net_growth_rate, growth_valid, input ready);
  modport sink (input valid, ammonium_total_out, nitrite_total_out, nitrate_total_out,
                net_growth_rate, growth_valid, output ready);
endinterface

interface mck_cfg_if import mck_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  conc_t                data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/mck_delay.sv]
// Enabled shift-register delay line used to carry side data along the pipeline.
// No package dependency.
module mck_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q = line_r[N-1];

endmodule

[rtl/mck_mul.sv]
// Two-stage unsigned multiplier built from four registered partial products.
// No package dependency.
module mck_mul #(
  parameter int WA = 47,
  parameter int WB = 41
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int LA = (WA + 1) / 2;
  localparam int HA = WA - LA;
  localparam int LB = (WB + 1) / 2;
  localparam int HB = WB - LB;
  localparam int PWID = WA + WB;

  logic [LA+LB-1:0] pp_ll_r;
  logic [LA+HB-1:0] pp_lh_r;
  logic [HA+LB-1:0] pp_hl_r;
  logic [HA+HB-1:0] pp_hh_r;
  logic [PWID-1:0]  p_r;

  // The low-by-high product carries the weight of the low half of b, the
  // high-by-low product that of the low half of a.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= (LA+LB)'(a[LA-1:0]) * (LA+LB)'(b[LB-1:0]);
      pp_lh_r <= (LA+HB)'(a[LA-1:0]) * (LA+HB)'(b[WB-1:LB]);
      pp_hl_r <= (HA+LB)'(a[WA-1:LA]) * (HA+LB)'(b[LB-1:0]);
      pp_hh_r <= (HA+HB)'(a[WA-1:LA]) * (HA+HB)'(b[WB-1:LB]);
      p_r     <= PWID'(pp_ll_r) + (PWID'(pp_lh_r) << LB) + (PWID'(pp_hl_r) << LA)
               + (PWID'(pp_hh_r) << (LA + LB));
    end
  end

  assign p = p_r;

endmodule

[rtl/mck_qdiv.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// The partial remainder must start below the divisor. No package dependency.
module mck_qdiv #(
  parameter int DW = 48,
  parameter int QW = 41
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o,
  output logic          dz_o
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] d_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign d_in   = d_i;
      assign low_in = low_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign d_in   = d_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_r[k] <= low_in << 1;
        q_r[k]   <= {q_in[QW-2:0], ge};
        d_r[k]   <= d_in;
      end
    end
  end

  assign q_o  = q_r[QW-1];
  assign dz_o = (d_r[QW-1] == '0);

endmodule

[rtl/monod_cell_kinetics_top.sv]
// Top level of the Monod cell kinetics block: input stage, ratio dividers,
// multiplier chain, uptake divider, nitrate reciprocal and saturating output stage.
// Depends on mck_pkg, mck_if, mck_delay, mck_mul and mck_qdiv.
//
// Usage: one grid cell enters per item on in_if (valid/ready). The block returns
// exactly one result item per cell on out_if, in order. Registers are written on
// cfg_if (index, data), which is always ready; write them only while no cell is in
// flight. An index beyond the register list is ignored.
//
// Most of the pipeline lies in the ratio dividers (FRAC_BITS + 1 stages, one quotient
// bit each) and the ammonium uptake divider (50 stages). Throughput is one cell per
// cycle while no result is held waiting at the output by out_if.ready low.
//
// Reset (rst_n low, synchronous) empties the pipeline and loads the register reset
// values: the biomass yield is 1.0, every other register is zero.
// When the receiver holds out_if.ready low while a result waits, the whole pipeline
// freezes and in_if.ready falls; nothing is dropped or repeated. While the output
// register is empty, items keep moving even if ready is low.
module monod_cell_kinetics_top import mck_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  mck_in_if.sink   in_if,
  mck_out_if.source out_if,
  mck_cfg_if.sink  cfg_if
);

  localparam int RW     = FRAC_BITS + 1;  // ratio width, values up to 1.0
  localparam int L_RAT  = RW;             // ratios ready
  localparam int L_M1   = L_RAT + 2;      // rate times ammonium term, maintenance
  localparam int L_M2   = L_M1 + 2;       // times nitrite term
  localparam int L_M3   = L_M2 + 2;       // times oxygen inhibition: the rate
  localparam int L_P    = L_M3 + 2;       // rate times biomass density
  localparam int L_PREP = L_P + 2;        // divider operands prepared
  localparam int SB_LAT = L_PREP + QDW;   // uptake quotients ready
  localparam int SB_W   = 1 + 3 * TW;
  localparam conc_t YIELD_RST = CW'(64'd1 << FRAC_BITS);
  // Nitrate division by 114: a dividend below 114 * 2^50 fits in CX_W bits, and
  // the rounded-up reciprocal with CX_W + DIVC_W shift bits is exact over that range.
  localparam int CX_W   = QDW + DIVC_W;
  localparam int CM_W   = CX_W + 1;
  localparam logic [127:0] C_RECIP_FULL =
    ((128'd1 << (CX_W + DIVC_W)) + 128'(NITRATE_DIV) - 128'd1) / 128'(NITRATE_DIV);
  localparam logic [CM_W-1:0] C_RECIP = CM_W'(C_RECIP_FULL);

  // Configuration registers.
  conc_t max_growth_r, yield_r, maint_r, decay_r, half_a_r, half_n_r, oxy_k_r;

  // Pipeline control: one enable for every stage.
  logic              en;
  logic [SB_LAT:0]   v_r;
  logic              out_valid_r;

  // Input stage.
  conc_t             s0_a_r, s0_n_r, s0_o_r, s0_dens_r;
  logic [TW-1:0]     s0_den_a_r, s0_den_n_r, s0_den_o_r;
  logic              s0_ghost_r;
  total_t            s0_ta_r, s0_tn_r, s0_tx_r;

  // Datapath signals.
  logic [RW-1:0]     ra, rn, rinh, rsat, rn_d, rinh_d;
  logic [CW+RW-1:0]  m1_full, mt_full, m2_full, m3_full;
  conc_t             m1, mt, m2, m3, mt_d, dens_d;
  logic [NET_W-1:0]  net_m3, net_d;
  logic [PW-1:0]     p_full, p_a_r, y_hi;
  logic [P100W-1:0]  p100_r, qf, c_hi;
  logic              y_ovf, c_ovf;
  conc_t             y_rem_r;
  logic [QDW-1:0]    y_low_r, y_q, c_q;
  logic [CX_W-1:0]   c_x_r;
  logic [CX_W+CM_W-1:0] c_prod;
  logic [CM_W-DIVC_W-1:0] c_quo;
  logic [QDW-1:0]    c_cap;
  logic              y_dz;
  logic [SB_W-1:0]   sb_in, sb_out;
  logic              f_ghost;
  total_t            f_ta, f_tn, f_tx;
  logic [QDW-1:0]    up_a, prod_x;
  logic [SUM_W-1:0]  sum_a, sum_n, sum_x, sum_net;

  // Output register.
  total_t            out_ta_r, out_tn_r, out_tx_r, out_net_r;
  logic              out_gv_r;

  // The pipeline advances whenever the output register is free or being emptied.
  assign en          = out_if.ready | ~out_valid_r;
  assign in_if.ready = en;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_growth_r <= '0;
      yield_r      <= YIELD_RST;
      maint_r      <= '0;
      decay_r      <= '0;
      half_a_r     <= '0;
      half_n_r     <= '0;
      oxy_k_r      <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_MAX_GROWTH: max_growth_r <= cfg_if.data;
        REG_YIELD:      yield_r      <= cfg_if.data;
        REG_MAINT:      maint_r      <= cfg_if.data;
        REG_DECAY:      decay_r      <= cfg_if.data;
        REG_HALF_A:     half_a_r     <= cfg_if.data;
        REG_HALF_N:     half_n_r     <= cfg_if.data;
        REG_OXY_K:      oxy_k_r      <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Valid bits travel beside the data and stand still with it during a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[SB_LAT-1:0], in_if.valid};
      out_valid_r <= v_r[SB_LAT];
    end
  end

  // Input stage: capture the cell and form the three ratio denominators.
  always_ff @(posedge clk) begin
    if (en) begin
      s0_a_r     <= in_if.conc_ammonium;
      s0_n_r     <= in_if.conc_nitrite;
      s0_o_r     <= in_if.conc_oxygen;
      s0_dens_r  <= in_if.biomass_density;
      s0_den_a_r <= {1'b0, half_a_r} + {1'b0, in_if.conc_ammonium};
      s0_den_n_r <= {1'b0, half_n_r} + {1'b0, in_if.conc_nitrite};
      s0_den_o_r <= {1'b0, oxy_k_r} + {1'b0, in_if.conc_oxygen};
      s0_ghost_r <= in_if.ghost_cell;
      s0_ta_r    <= in_if.ammonium_total_in;
      s0_tn_r    <= in_if.nitrite_total_in;
      s0_tx_r    <= in_if.nitrate_total_in;
    end
  end

  // Ratios X/(K+X) and, for inhibition, K/(K+X) as fractions. The numerator never
  // exceeds its denominator: step one compares it whole, the later steps shift in zeros.
  mck_qdiv #(.DW(TW), .QW(RW)) u_rat_a (
    .clk(clk), .en(en), .rem_i(TW'(s0_a_r >> 1)), .low_i({s0_a_r[0], {FRAC_BITS{1'b0}}}),
    .d_i(s0_den_a_r), .q_o(ra), .dz_o()
  );
  mck_qdiv #(.DW(TW), .QW(RW)) u_rat_n (
    .clk(clk), .en(en), .rem_i(TW'(s0_n_r >> 1)), .low_i({s0_n_r[0], {FRAC_BITS{1'b0}}}),
    .d_i(s0_den_n_r), .q_o(rn), .dz_o()
  );
  mck_qdiv #(.DW(TW), .QW(RW)) u_rat_inh (
    .clk(clk), .en(en), .rem_i(TW'(oxy_k_r >> 1)), .low_i({oxy_k_r[0], {FRAC_BITS{1'b0}}}),
    .d_i(s0_den_o_r), .q_o(rinh), .dz_o()
  );
  mck_qdiv #(.DW(TW), .QW(RW)) u_rat_sat (
    .clk(clk), .en(en), .rem_i(TW'(s0_o_r >> 1)), .low_i({s0_o_r[0], {FRAC_BITS{1'b0}}}),
    .d_i(s0_den_o_r), .q_o(rsat), .dz_o()
  );

  // A zero denominator would give an all-ones quotient; force those ratios to zero.
  logic [RW-1:0] ra_z, rn_z, rinh_z, rsat_z;
  logic          dz_a, dz_n, dz_o;
  mck_delay #(.W(3), .N(L_RAT)) u_dz_dly (
    .clk(clk), .en(en),
    .d({s0_den_a_r == '0, s0_den_n_r == '0, s0_den_o_r == '0}),
    .q({dz_a, dz_n, dz_o})
  );
  assign ra_z   = dz_a ? '0 : ra;
  assign rn_z   = dz_n ? '0 : rn;
  assign rinh_z = dz_o ? '0 : rinh;
  assign rsat_z = dz_o ? '0 : rsat;

  // Multiplier chain for the rate, with the maintenance term alongside.
  mck_mul #(.WA(CW), .WB(RW)) u_mul_a (
    .clk(clk), .en(en), .a(max_growth_r), .b(ra_z), .p(m1_full)
  );
  mck_mul #(.WA(CW), .WB(RW)) u_mul_mt (
    .clk(clk), .en(en), .a(maint_r), .b(rsat_z), .p(mt_full)
  );
  assign m1 = m1_full[FRAC_BITS+CW-1:FRAC_BITS];
  assign mt = mt_full[FRAC_BITS+CW-1:FRAC_BITS];

  mck_delay #(.W(RW), .N(L_M1 - L_RAT)) u_rn_dly (
    .clk(clk), .en(en), .d(rn_z), .q(rn_d)
  );
  mck_mul #(.WA(CW), .WB(RW)) u_mul_n (
    .clk(clk), .en(en), .a(m1), .b(rn_d), .p(m2_full)
  );
  assign m2 = m2_full[FRAC_BITS+CW-1:FRAC_BITS];

  mck_delay #(.W(RW), .N(L_M2 - L_RAT)) u_rinh_dly (
    .clk(clk), .en(en), .d(rinh_z), .q(rinh_d)
  );
  mck_mul #(.WA(CW), .WB(RW)) u_mul_o (
    .clk(clk), .en(en), .a(m2), .b(rinh_d), .p(m3_full)
  );
  assign m3 = m3_full[FRAC_BITS+CW-1:FRAC_BITS];

  // Net growth: rate minus maintenance minus decay, carried to the output stage.
  mck_delay #(.W(CW), .N(L_M3 - L_M1)) u_mt_dly (
    .clk(clk), .en(en), .d(mt), .q(mt_d)
  );
  assign net_m3 = {2'b00, m3} - {2'b00, mt_d} - {2'b00, decay_r};
  mck_delay #(.W(NET_W), .N(SB_LAT - L_M3)) u_net_dly (
    .clk(clk), .en(en), .d(net_m3), .q(net_d)
  );

  // Full product of rate and biomass density.
  mck_delay #(.W(CW), .N(L_M3)) u_dens_dly (
    .clk(clk), .en(en), .d(s0_dens_r), .q(dens_d)
  );
  mck_mul #(.WA(CW), .WB(CW)) u_mul_p (
    .clk(clk), .en(en), .a(m3), .b(dens_d), .p(p_full)
  );

  // Divider operands. An uptake quotient of 2^50 or more becomes all ones, which the
  // output stage caps at 2^49 like any large one; too large a nitrate dividend saturates.
  assign y_hi  = p_a_r >> QDW;
  assign y_ovf = y_hi >= PW'(yield_r);
  assign qf    = p100_r >> FRAC_BITS;
  assign c_hi  = qf >> QDW;
  assign c_ovf = c_hi >= P100W'(NITRATE_DIV);

  always_ff @(posedge clk) begin
    if (en) begin
      p_a_r   <= p_full;
      p100_r  <= P100W'(p_full) * P100W'(NITRATE_MUL);
      y_rem_r <= y_ovf ? (yield_r - CW'(1)) : y_hi[CW-1:0];
      y_low_r <= y_ovf ? '1 : p_a_r[QDW-1:0];
      c_x_r   <= c_ovf ? '1 : qf[CX_W-1:0];
    end
  end

  // Ammonium uptake is the product over the yield.
  mck_qdiv #(.DW(CW), .QW(QDW)) u_div_y (
    .clk(clk), .en(en), .rem_i(y_rem_r), .low_i(y_low_r), .d_i(yield_r),
    .q_o(y_q), .dz_o(y_dz)
  );

  // Nitrate production is the product over 1.14 in the same fixed-point scale:
  // the scaled product divided by 114, done as a multiplication by the reciprocal.
  // The capped quotient then waits for the uptake divider.
  mck_mul #(.WA(CX_W), .WB(CM_W)) u_mul_c (
    .clk(clk), .en(en), .a(c_x_r), .b(C_RECIP), .p(c_prod)
  );
  assign c_quo = c_prod[CX_W+CM_W-1:CX_W+DIVC_W];
  assign c_cap = (c_quo > (CM_W-DIVC_W)'(TERM_CAP)) ? TERM_CAP : c_quo[QDW-1:0];
  mck_delay #(.W(QDW), .N(SB_LAT - L_PREP - 2)) u_c_dly (
    .clk(clk), .en(en), .d(c_cap), .q(c_q)
  );

  // Ghost flag and the running totals ride alongside the whole datapath.
  assign sb_in = {s0_ghost_r, s0_ta_r, s0_tn_r, s0_tx_r};
  mck_delay #(.W(SB_W), .N(SB_LAT)) u_sb_dly (
    .clk(clk), .en(en), .d(sb_in), .q(sb_out)
  );
  assign {f_ghost, f_ta, f_tn, f_tx} = sb_out;

  // Output stage: cap the terms, update the totals and saturate; ghost cells pass through.
  always_comb begin
    up_a    = y_dz ? '0 : ((y_q > TERM_CAP) ? TERM_CAP : y_q);
    prod_x  = c_q;
    sum_a   = {{(SUM_W-TW){f_ta[TW-1]}}, f_ta} - {2'b00, up_a};
    sum_n   = {{(SUM_W-TW){f_tn[TW-1]}}, f_tn} - {2'b00, up_a} - {2'b00, prod_x};
    sum_x   = {{(SUM_W-TW){f_tx[TW-1]}}, f_tx} + {2'b00, prod_x};
    sum_net = {{(SUM_W-NET_W){net_d[NET_W-1]}}, net_d};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_ghost) begin
        out_ta_r  <= f_ta;
        out_tn_r  <= f_tn;
        out_tx_r  <= f_tx;
        out_net_r <= '0;
        out_gv_r  <= 1'b0;
      end else begin
        out_ta_r  <= sat_total(sum_a);
        out_tn_r  <= sat_total(sum_n);
        out_tx_r  <= sat_total(sum_x);
        out_net_r <= sat_total(sum_net);
        out_gv_r  <= 1'b1;
      end
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.ammonium_total_out = out_ta_r;
  assign out_if.nitrite_total_out  = out_tn_r;
  assign out_if.nitrate_total_out  = out_tx_r;
  assign out_if.net_growth_rate    = out_net_r;
  assign out_if.growth_valid       = out_gv_r;

`ifndef SYNTHESIS
  // Input back-pressure only ever comes from a result waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_valid_r)
    else $error("input stalled while the output register is empty");

  // A frozen pipeline keeps every in-flight item where it is.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline valid bits moved during a stall");

  // A ghost cell result never carries a growth rate.
  a_ghost_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_gv_r |-> out_net_r == '0)
    else $error("ghost cell result with nonzero growth rate");
`endif

endmodule
